// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that check their own behavior.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle property violated");

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle property violated");

`endif

// ===== hw/rtl/rbdo_pkg.sv =====
// Shared types and constants for the ring buffer deque with overwrite.
// No dependencies.
package rbdo_pkg;

   localparam int DEPTH      = 16;
   localparam int WORD_WIDTH = 32;
   localparam int PTR_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CAP_W      = 5;
   localparam int FILL_W     = 5;
   localparam int ACT_W      = 2;
   localparam int STAT_W     = 2;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH     = 2'd0,
      ACT_READ_NEW = 2'd1,
      ACT_READ_OLD = 2'd2,
      ACT_CLEAR    = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request fields
      logic exec;      // carry out the latched request
   } ctrl_cmd_type;

endpackage

// ===== hw/rtl/ring_buffer_deque_overwrite_unit.sv =====
// Top level of the ring buffer deque with overwrite.
// Depends on rbdo_pkg, rbdo_ctrl, rbdo_datapath, rbdo_ram and assert_macros.svh.
//
//   Channel    Handshake              Payload
//   request    start / busy           req_action, req_data_in, req_overwrite_ok,
//                                     req_remove_entry, req_clear_after
//   response   rsp_valid (strobe)     rsp_data_out, rsp_status, rsp_fill_count
//   csr        csr_valid / csr_ready  csr_capacity
//
// A request transfers on a clock edge with start high and busy low. The next
// cycle (busy high) executes it: at most one RAM access plus the pointer and
// count update. The cycle after that shows the response for exactly one cycle,
// with RAM read data straight from the registered read port.
// A new request may transfer during the response cycle, but not while one executes.
// The receiver cannot stall the response.
// Synchronous reset empties the ring and sets capacity to 16; storage keeps
// whatever it held and needs no clearing pass.
`include "assert_macros.svh"

module ring_buffer_deque_overwrite_unit
   import rbdo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic [ACT_W-1:0]      req_action,
   input  logic [WORD_WIDTH-1:0] req_data_in,
   input  logic                  req_overwrite_ok,
   input  logic                  req_remove_entry,
   input  logic                  req_clear_after,
   // response channel
   output logic                  rsp_valid,
   output logic [WORD_WIDTH-1:0] rsp_data_out,
   output logic [STAT_W-1:0]     rsp_status,
   output logic [FILL_W-1:0]     rsp_fill_count,
   // capacity register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CAP_W-1:0]      csr_capacity
);

   ctrl_cmd_type cmd;

   // Users must send capacity writes only while quiet; unenforced, taken at once.
   assign csr_ready = 1'b1;

   // Sequence each request: latch, execute, reply.
   rbdo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // Hold the ring state and storage; advance pointers on execute.
   rbdo_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_action       (req_action),
      .req_data_in      (req_data_in),
      .req_overwrite_ok (req_overwrite_ok),
      .req_remove_entry (req_remove_entry),
      .req_clear_after  (req_clear_after),
      .cap_wr           (csr_valid && csr_ready),
      .cap_data         (csr_capacity),
      .rsp_data_out     (rsp_data_out),
      .rsp_status       (rsp_status),
      .rsp_fill_count   (rsp_fill_count)
   );

   // A transfer always leads to an execute cycle, which always leads to a reply.
   `ASSERT_NEXT(a_accept_then_busy, clock, reset, start && !busy, busy)
   `ASSERT_NEXT(a_busy_then_reply, clock, reset, busy, rsp_valid && !busy)
   // The reported fill count never exceeds DEPTH.
   `ASSERT_IMPLIES(a_fill_bounded, clock, reset, rsp_valid, rsp_fill_count <= FILL_W'(DEPTH))
   // A refused push only happens on a non-empty ring.
   `ASSERT_IMPLIES(a_full_not_empty, clock, reset, rsp_valid && rsp_status == STAT_FULL, rsp_fill_count != '0)

endmodule

// ===== hw/rtl/rbdo_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbdo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rbdo_ctrl.sv =====
// Sequencing controller: accept, execute, reply.
// Depends on rbdo_pkg.
module rbdo_ctrl
   import rbdo_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_valid,
   output ctrl_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REPLY
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      valid_ff;
   logic      accept;

   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_EXEC;
                  busy_ff  <= 1'b1;
               end
               valid_ff <= 1'b0;
            end
            ST_EXEC: begin
               state_ff <= ST_REPLY;
               busy_ff  <= 1'b0;
               valid_ff <= 1'b1;
            end
            ST_REPLY: begin
               // a new request may enter while the reply is on the ports
               if (accept) begin
                  state_ff <= ST_EXEC;
                  busy_ff  <= 1'b1;
               end else begin
                  state_ff <= ST_IDLE;
               end
               valid_ff <= 1'b0;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
               valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign busy        = busy_ff;
   assign rsp_valid   = valid_ff;
   assign cmd.capture = accept;
   assign cmd.exec    = busy_ff;

endmodule

// ===== hw/rtl/rbdo_datapath.sv =====
// Datapath: request latch, pointers, count, capacity register and storage RAM.
// Depends on rbdo_pkg and rbdo_ram.
module rbdo_datapath
   import rbdo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   input  logic [ACT_W-1:0]      req_action,
   input  logic [WORD_WIDTH-1:0] req_data_in,
   input  logic                  req_overwrite_ok,
   input  logic                  req_remove_entry,
   input  logic                  req_clear_after,
   input  logic                  cap_wr,
   input  logic [CAP_W-1:0]      cap_data,
   output logic [WORD_WIDTH-1:0] rsp_data_out,
   output logic [STAT_W-1:0]     rsp_status,
   output logic [FILL_W-1:0]     rsp_fill_count
);

   // Latched request
   action_type            act_ff;
   logic [WORD_WIDTH-1:0] data_ff;
   logic                  ovw_ff;
   logic                  rem_ff;
   logic                  clr_ff;

   // Buffer state
   logic [CAP_W-1:0] cap_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   status_type       status_ff, status_in;
   logic             rd_sel_ff, rd_sel_in;

   logic [CNT_W-1:0]      eff_cap;
   logic [CNT_W-1:0]      cap_m1;
   logic [CNT_W-1:0]      head_inc;
   logic [CNT_W-1:0]      tail_inc;
   logic [PTR_W-1:0]      head_next;
   logic [PTR_W-1:0]      tail_next;
   logic [PTR_W-1:0]      head_prev;
   logic                  empty;
   logic                  full;
   logic                  wr_en;
   logic [PTR_W-1:0]      wr_addr;
   logic                  rd_en;
   logic [PTR_W-1:0]      rd_addr;
   logic [WORD_WIDTH-1:0] rd_data;

   always_comb begin
      priority if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (cap_ff > CAP_W'(DEPTH)) begin
         eff_cap = CNT_W'(DEPTH);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   assign cap_m1    = eff_cap - CNT_W'(1);
   assign head_inc  = CNT_W'(head_ff) + CNT_W'(1);
   assign tail_inc  = CNT_W'(tail_ff) + CNT_W'(1);
   assign head_next = (head_inc >= eff_cap) ? '0 : head_inc[PTR_W-1:0];
   assign tail_next = (tail_inc >= eff_cap) ? '0 : tail_inc[PTR_W-1:0];
   assign head_prev = (head_ff == '0) ? cap_m1[PTR_W-1:0] : head_ff - PTR_W'(1);
   assign empty     = (count_ff == '0);
   assign full      = (head_next == tail_ff) || (count_ff >= eff_cap);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = status_ff;
      rd_sel_in = rd_sel_ff;
      wr_en     = 1'b0;
      wr_addr   = head_next;
      rd_en     = 1'b0;
      rd_addr   = (act_ff == ACT_READ_NEW) ? head_ff : tail_ff;
      if (cmd.exec) begin
         status_in = STAT_OK;
         rd_sel_in = 1'b0;
         unique case (act_ff)
            ACT_PUSH: begin
               if (empty) begin
                  // restart the ring at entry zero
                  head_in  = '0;
                  tail_in  = '0;
                  count_in = CNT_W'(1);
                  wr_en    = 1'b1;
                  wr_addr  = '0;
               end else if (full && !ovw_ff) begin
                  status_in = STAT_FULL;
               end else begin
                  head_in = head_next;
                  wr_en   = 1'b1;
                  if (full) begin
                     // drop the oldest entry
                     tail_in = tail_next;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
            end
            ACT_READ_NEW, ACT_READ_OLD: begin
               if (empty) begin
                  status_in = STAT_EMPTY;
               end else begin
                  rd_en     = 1'b1;
                  rd_sel_in = 1'b1;
                  if (clr_ff) begin
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                  end else if (rem_ff) begin
                     if (act_ff == ACT_READ_NEW) begin
                        head_in = head_prev;
                     end else begin
                        tail_in = tail_next;
                     end
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
            ACT_CLEAR: begin
               head_in  = '0;
               tail_in  = '0;
               count_in = '0;
            end
            default: begin
               status_in = STAT_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (cap_wr) begin
            cap_ff <= cap_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= action_type'(req_action);
         data_ff <= req_data_in;
         ovw_ff  <= req_overwrite_ok;
         rem_ff  <= req_remove_entry;
         clr_ff  <= req_clear_after;
      end
      status_ff <= status_in;
      rd_sel_ff <= rd_sel_in;
   end

   rbdo_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (data_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_data_out   = rd_sel_ff ? rd_data : '0;
   assign rsp_status     = status_ff;
   assign rsp_fill_count = FILL_W'(count_ff);

endmodule

// ===== tb/ring_buffer_deque_overwrite_checker.sv =====
// Response checker for the ring buffer deque with overwrite.
// Depends on rbdo_pkg; tracks the request, response and csr channels and predicts
// every response from its own model of the ring.
module ring_buffer_deque_overwrite_checker
   import rbdo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [ACT_W-1:0]      req_action,
   input  logic [WORD_WIDTH-1:0] req_data_in,
   input  logic                  req_overwrite_ok,
   input  logic                  req_remove_entry,
   input  logic                  req_clear_after,
   input  logic                  rsp_valid,
   input  logic [WORD_WIDTH-1:0] rsp_data_out,
   input  logic [STAT_W-1:0]     rsp_status,
   input  logic [FILL_W-1:0]     rsp_fill_count,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CAP_W-1:0]      csr_capacity,
   output int                    mismatch_count,
   output int                    replies_outstanding
);

   typedef struct packed {
      logic [WORD_WIDTH-1:0] data;
      status_type            status;
      logic [FILL_W-1:0]     fill;
   } ring_reply_type;

   logic [WORD_WIDTH-1:0] ring_mem [DEPTH];
   logic [PTR_W-1:0]      newest_idx;
   logic [PTR_W-1:0]      oldest_idx;
   logic [FILL_W-1:0]     held;
   logic [CAP_W-1:0]      cap_reg;
   ring_reply_type        replies_due [$];

   initial begin
      for (int i = 0; i < DEPTH; i++) ring_mem[i] = '0;
      newest_idx          = '0;
      oldest_idx          = '0;
      held                = '0;
      cap_reg             = CAP_RESET;
      mismatch_count      = 0;
      replies_outstanding = 0;
   end

   // Capacity as the ring uses it: zero acts as one, anything past DEPTH as DEPTH.
   function automatic int usable_capacity();
      if (cap_reg == '0) return 1;
      if (int'(cap_reg) > DEPTH) return DEPTH;
      return int'(cap_reg);
   endfunction

   function automatic void empty_ring();
      newest_idx = '0;
      oldest_idx = '0;
      held       = '0;
   endfunction

   // Apply one request to the ring and return the response it should produce.
   function automatic ring_reply_type advance_ring(input action_type            act,
                                                   input logic [WORD_WIDTH-1:0] word,
                                                   input logic                  ovw,
                                                   input logic                  rem,
                                                   input logic                  clr);
      int             lim;
      int             nxt;
      logic           full;
      ring_reply_type r;
      lim      = usable_capacity();
      r.data   = '0;
      r.status = STAT_OK;
      case (act)
         ACT_PUSH: begin
            if (held == '0) begin
               newest_idx  = '0;
               oldest_idx  = '0;
               ring_mem[0] = word;
               held        = FILL_W'(1);
            end else begin
               nxt = int'(newest_idx) + 1;
               if (nxt >= lim) nxt = 0;
               full = (nxt == int'(oldest_idx)) || (int'(held) >= lim);
               if (full && !ovw) begin
                  r.status = STAT_FULL;
               end else begin
                  newest_idx           = PTR_W'(nxt);
                  ring_mem[newest_idx] = word;
                  if (full) begin
                     nxt        = int'(oldest_idx) + 1;
                     oldest_idx = (nxt >= lim) ? '0 : PTR_W'(nxt);
                  end else begin
                     held = held + 1'b1;
                  end
               end
            end
         end
         ACT_READ_NEW, ACT_READ_OLD: begin
            if (held == '0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.data = (act == ACT_READ_NEW) ? ring_mem[newest_idx] : ring_mem[oldest_idx];
               if (clr) begin
                  empty_ring();
               end else if (rem) begin
                  if (act == ACT_READ_NEW) begin
                     newest_idx = (newest_idx == '0) ? PTR_W'(lim - 1) : newest_idx - 1'b1;
                  end else begin
                     nxt        = int'(oldest_idx) + 1;
                     oldest_idx = (nxt >= lim) ? '0 : PTR_W'(nxt);
                  end
                  held = held - 1'b1;
               end
            end
         end
         default: empty_ring();
      endcase
      r.fill = held;
      return r;
   endfunction

   always @(posedge clock) begin
      ring_reply_type due;
      if (reset) begin
         empty_ring();
         cap_reg = CAP_RESET;
         replies_due.delete();
      end else begin
         // Check the response first: it always belongs to an earlier request.
         if (rsp_valid) begin
            if (replies_due.size() == 0) begin
               $error("response transfer with no response outstanding");
               mismatch_count++;
            end else begin
               due = replies_due.pop_front();
               if (rsp_data_out !== due.data) begin
                  $error("rsp_data_out: expected %h, actual %h", due.data, rsp_data_out);
                  mismatch_count++;
               end
               if (rsp_status !== due.status) begin
                  $error("rsp_status: expected %0d, actual %0d", due.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_fill_count !== due.fill) begin
                  $error("rsp_fill_count: expected %0d, actual %0d", due.fill, rsp_fill_count);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            due = advance_ring(action_type'(req_action), req_data_in, req_overwrite_ok,
                               req_remove_entry, req_clear_after);
            replies_due.push_back(due);
         end
         if (csr_valid && csr_ready) cap_reg = csr_capacity;
      end
      replies_outstanding = replies_due.size();
   end

endmodule

// ===== tb/ring_buffer_deque_overwrite_unit_test.sv =====
// Testbench top for ring_buffer_deque_overwrite_unit: clock, reset, stimulus and verdict.
// Depends on rbdo_pkg, the unit itself and ring_buffer_deque_overwrite_checker.
module ring_buffer_deque_overwrite_unit_test;
   import rbdo_pkg::*;

   // Cycles without any transfer before the run is declared hung.
   localparam int STALL_LIMIT    = 300;
   localparam int PHASE_ITEMS    = 142;
   localparam int NUM_PHASES     = 10;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [ACT_W-1:0]      req_action;
   logic [WORD_WIDTH-1:0] req_data_in;
   logic                  req_overwrite_ok;
   logic                  req_remove_entry;
   logic                  req_clear_after;
   logic                  rsp_valid;
   logic [WORD_WIDTH-1:0] rsp_data_out;
   logic [STAT_W-1:0]     rsp_status;
   logic [FILL_W-1:0]     rsp_fill_count;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CAP_W-1:0]      csr_capacity;
   int                    mismatch_count;
   int                    replies_outstanding;
   int                    quiet_cycles;

   // Capacity per phase: the extremes, out-of-range codes (0 acts as 1,
   // above 16 acts as 16) and a few ordinary sizes.
   logic [CAP_W-1:0] phase_capacity [NUM_PHASES] =
      '{5'd1, 5'd16, 5'd2, 5'd0, 5'd7, 5'd31, 5'd17, 5'd3, 5'd12, 5'd16};

   ring_buffer_deque_overwrite_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_data_in      (req_data_in),
      .req_overwrite_ok (req_overwrite_ok),
      .req_remove_entry (req_remove_entry),
      .req_clear_after  (req_clear_after),
      .rsp_valid        (rsp_valid),
      .rsp_data_out     (rsp_data_out),
      .rsp_status       (rsp_status),
      .rsp_fill_count   (rsp_fill_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_capacity     (csr_capacity)
   );

   ring_buffer_deque_overwrite_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_data_in         (req_data_in),
      .req_overwrite_ok    (req_overwrite_ok),
      .req_remove_entry    (req_remove_entry),
      .req_clear_after     (req_clear_after),
      .rsp_valid           (rsp_valid),
      .rsp_data_out        (rsp_data_out),
      .rsp_status          (rsp_status),
      .rsp_fill_count      (rsp_fill_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_capacity        (csr_capacity),
      .mismatch_count      (mismatch_count),
      .replies_outstanding (replies_outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog: count cycles in which no channel transfers anything.
   initial quiet_cycles = 0;
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Present one request at the current falling edge and hold it until it
   // transfers. Leave start high on return so a following request can go
   // back to back; the caller lowers it for a gap.
   task automatic issue_request(input action_type            act,
                                input logic [WORD_WIDTH-1:0] word,
                                input logic                  ovw,
                                input logic                  rem,
                                input logic                  clr);
      start            <= 1'b1;
      req_action       <= act;
      req_data_in      <= word;
      req_overwrite_ok <= ovw;
      req_remove_entry <= rem;
      req_clear_after  <= clr;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Drop start and idle the sender for a number of cycles.
   task automatic idle_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Hold the sender until every outstanding response has arrived.
   task automatic drain_responses();
      start <= 1'b0;
      while (replies_outstanding != 0) @(negedge clock);
   endtask

   // Write the capacity register and wait for the transfer.
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      csr_valid    <= 1'b1;
      csr_capacity <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One random request. push_pct steers how often the ring runs full.
   task automatic random_request(input int push_pct);
      int                    roll;
      action_type            act;
      logic [WORD_WIDTH-1:0] word;
      roll = $urandom_range(0, 99);
      if (roll < push_pct)                act = ACT_PUSH;
      else if (roll >= 94)                act = ACT_CLEAR;
      else if ($urandom_range(0, 1) == 0) act = ACT_READ_NEW;
      else                                act = ACT_READ_OLD;
      case ($urandom_range(0, 9))
         0:       word = '0;
         1:       word = '1;
         default: word = $urandom;
      endcase
      issue_request(act, word, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0,
                    $urandom_range(0, 9) == 0);
   endtask

   initial begin
      int push_pct;
      // Drive every input to a known value and hold reset.
      reset            = 1'b1;
      start            = 1'b0;
      req_action       = ACT_PUSH;
      req_data_in      = '0;
      req_overwrite_ok = 1'b0;
      req_remove_entry = 1'b0;
      req_clear_after  = 1'b0;
      csr_valid        = 1'b0;
      csr_capacity     = CAP_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset capacity of 16.
      // Read an empty ring both ways, with remove and clear set: nothing moves.
      issue_request(ACT_READ_NEW, '0, 1'b0, 1'b1, 1'b1);
      issue_request(ACT_READ_OLD, '0, 1'b0, 1'b1, 1'b1);
      // Fill all 16 entries; the first push lands at entry 0. After this every
      // storage entry has been written, so later capacity changes can never
      // expose a stale entry.
      issue_request(ACT_PUSH, '0, 1'b0, 1'b0, 1'b0);
      issue_request(ACT_PUSH, '1, 1'b0, 1'b0, 1'b0);
      for (int i = 2; i < DEPTH; i++) issue_request(ACT_PUSH, $urandom, 1'b0, 1'b0, 1'b0);
      // Full ring: refuse without overwrite, then drop the oldest with it.
      issue_request(ACT_PUSH, 32'hDEAD_BEEF, 1'b0, 1'b0, 1'b0);
      issue_request(ACT_PUSH, 32'hA5A5_5A5A, 1'b1, 1'b0, 1'b0);
      // Peek the newest, remove the oldest, remove the newest.
      issue_request(ACT_READ_NEW, '0, 1'b0, 1'b0, 1'b0);
      issue_request(ACT_READ_OLD, '0, 1'b0, 1'b1, 1'b0);
      issue_request(ACT_READ_NEW, '0, 1'b0, 1'b1, 1'b0);
      // Read the oldest and clear everything afterwards.
      issue_request(ACT_READ_OLD, '0, 1'b0, 1'b1, 1'b1);
      // Push into the emptied ring, then clear it with the clear action.
      issue_request(ACT_PUSH, 32'h0123_4567, 1'b1, 1'b0, 1'b0);
      issue_request(ACT_CLEAR, '1, 1'b1, 1'b1, 1'b1);
      drain_responses();

      // Random phases, one capacity each. Entries stay in the ring across a
      // capacity change, so a lowered capacity with entries held is covered.
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_capacity(phase_capacity[p]);
         case (p % 3)
            0:       push_pct = 70;
            1:       push_pct = 45;
            default: push_pct = 30;
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            random_request(push_pct);
            // Pause mid-phase until the pipeline is empty.
            if (n == PHASE_ITEMS / 2) drain_responses();
            // Idle in random bursts, except in the final phase.
            else if (p != NUM_PHASES - 1 && $urandom_range(0, 4) == 0)
               idle_sender($urandom_range(1, 14));
         end
         drain_responses();
      end

      // Let the block settle, then give the verdict.
      repeat (4) @(negedge clock);
      if (mismatch_count == 0 && replies_outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
